// ===== rtl/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the morphing waveshape oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_W = 32;
    localparam int DIV_W   = 27;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic signed [20:0] MORPH_GATE_TOP = 21'sd30700;
    localparam logic signed [17:0] FULL_SCALE     = 18'sd32767;
    localparam logic signed [17:0] QUARTER_SCALE  = 18'sd16384;
    localparam logic signed [17:0] WRAP_SPAN      = 18'sd65535;
    localparam logic signed [15:0] PWM_SELECT     = 16'sd10922;
    localparam logic signed [17:0] SEG_TRI        = 18'sd21845;
    localparam logic signed [17:0] SEG_SQUARE     = 18'sd43689;
    localparam logic signed [17:0] SEG_SAW        = 18'sd65534;
    localparam logic [DIV_W-1:0]   RAMP_DIVIDEND  = DIV_W'(1 << 26);
    localparam logic [DIV_W-1:0]   SAW_DIVIDEND   = DIV_W'(32768);
    localparam logic [16:0]        HALF_RANGE     = 17'd32768;

    // One phase update handed from the front to the shaping back end.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic signed [31:0] incr;
        logic signed [15:0] morph;
        logic signed [15:0] wave;
    } mwo_job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_RDIV,
        B_RAMP,
        B_SHAPE,
        B_SINE,
        B_SDIV,
        B_SAWM,
        B_SAWS,
        B_BLEND,
        B_OUT
    } back_state_t;

endpackage

// ===== rtl/mwo_if.sv =====
// ----------------------------------------------------------------------------
// mwo_ctrl_if / mwo_audio_if
// Valid/ready channels carrying control samples in and audio samples out.
// ----------------------------------------------------------------------------
interface mwo_ctrl_if;
    logic               valid;
    logic               ready;
    logic [30:0]        freq_step;
    logic signed [15:0] fm_amount;
    logic signed [15:0] morph_amount;
    logic signed [15:0] wave_select;
    logic               sync_pulse;
    logic signed [15:0] sync_phase;

    modport source (
        output valid, freq_step, fm_amount, morph_amount, wave_select,
               sync_pulse, sync_phase,
        input  ready
    );
    modport sink (
        input  valid, freq_step, fm_amount, morph_amount, wave_select,
               sync_pulse, sync_phase,
        output ready
    );
endinterface

interface mwo_audio_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               sync_high;

    modport source (
        output valid, sample_out, sync_high,
        input  ready
    );
    modport sink (
        input  valid, sample_out, sync_high,
        output ready
    );
endinterface

// ===== rtl/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Accepts control samples, applies FM and sync to the phase accumulator and
// clips the morph, then queues the job for the back end.
// ----------------------------------------------------------------------------
module mwo_front (
    input  logic              clk,
    input  logic              rst_n,
    mwo_ctrl_if.sink          ctrl,
    output logic              push,
    output mwo_pkg::mwo_job_t job,
    input  logic              full
);
    import mwo_pkg::*;

    front_state_t        state_reg, state_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [30:0]         step_reg;
    logic signed [15:0]  fm_reg;
    logic signed [15:0]  morph_reg;
    logic signed [15:0]  wave_reg;
    logic                sync_reg;
    logic signed [15:0]  sph_reg;
    logic signed [63:0]  prod_reg;

    logic signed [31:0]  fm_mult;
    logic signed [63:0]  prod;
    logic signed [31:0]  incr;
    logic [PHASE_W-1:0]  phase_adv;
    logic signed [16:0]  sph_off;
    logic [31:0]         sph_ext;
    logic [31:0]         sync_load;
    logic [PHASE_W-1:0]  phase_next;
    logic signed [20:0]  gate_raw;
    logic signed [20:0]  gate;
    logic signed [20:0]  morph_ext;
    logic signed [15:0]  morph_clip;
    logic                accept;

    assign accept = ctrl.valid && ctrl.ready;

    assign fm_mult = {fm_reg[15], fm_reg, 15'b0} + (32'sd1 <<< 28);
    assign prod    = $signed({1'b0, step_reg}) * fm_mult;
    assign incr    = prod_reg[63:32];

    assign phase_adv = phase_reg + {incr[28:0], 3'b000};
    assign sph_off   = {sph_reg[15], sph_reg} + 17'sd32767;
    assign sph_ext   = {{15{sph_off[16]}}, sph_off};
    // Multiplying by 32769 is a shift by fifteen plus the value itself.
    assign sync_load = (sph_ext << 15) + sph_ext;
    assign phase_next = sync_reg ? ({phase_adv[31], 31'b0} + sync_load) : phase_adv;

    assign gate_raw  = MORPH_GATE_TOP - $signed({2'b00, step_reg[30:12]});
    assign gate      = (gate_raw < 0) ? 21'sd0 : gate_raw;
    assign morph_ext = {{5{morph_reg[15]}}, morph_reg};

    always_comb
    begin
        priority if (morph_ext > gate)
        begin
            morph_clip = gate[15:0];
        end
        else if (morph_ext < -gate)
        begin
            morph_clip = 16'(-gate);
        end
        else
        begin
            morph_clip = morph_reg;
        end
    end

    assign job.phase = phase_next;
    assign job.incr  = incr;
    assign job.morph = morph_clip;
    assign job.wave  = wave_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.ready = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:  ctrl.ready = 1'b1;
            F_MUL:   ;
            F_PUSH:  push = !full;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg  <= ctrl.freq_step;
            fm_reg    <= ctrl.fm_amount;
            morph_reg <= ctrl.morph_amount;
            wave_reg  <= ctrl.wave_select;
            sync_reg  <= ctrl.sync_pulse;
            sph_reg   <= ctrl.sync_phase;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= prod;
        end
    end

endmodule

// ===== rtl/mwo_fifo.sv =====
// ----------------------------------------------------------------------------
// mwo_fifo
// Short job queue between the phase front end and the shaping back end.
// ----------------------------------------------------------------------------
module mwo_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mwo_pkg::mwo_job_t wr_job,
    output logic              full,
    input  logic              pop,
    output mwo_pkg::mwo_job_t rd_job,
    output logic              empty
);
    import mwo_pkg::*;

    mwo_job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [FIFO_PTR_W:0]       count_reg;

    assign full   = (count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/mwo_div.sv =====
// ----------------------------------------------------------------------------
// mwo_div
// Restoring divider, one quotient bit per cycle, shared by the ramp bend and
// the saw softening.
// ----------------------------------------------------------------------------
module mwo_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mwo_pkg::DIV_W-1:0]  dividend,
    input  logic [15:0]                divisor,
    output logic                       done,
    output logic [mwo_pkg::DIV_W-1:0]  quotient
);
    import mwo_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [16:0]      rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      den_reg;
    logic [16:0]      trial;
    logic             fits;

    assign trial    = {rem_reg[15:0], quo_reg[DIV_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Turns a queued phase into a ramp, bends it by the morph and blends the
// sine, triangle, square and softened saw shapes into the output sample.
// ----------------------------------------------------------------------------
module mwo_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mwo_pkg::mwo_job_t rd_job,
    input  logic              empty,
    output logic              pop,
    mwo_audio_if.source       audio
);
    import mwo_pkg::*;

    back_state_t         state_reg, state_next;
    mwo_job_t            job_reg;
    logic [15:0]         x_reg;
    logic [15:0]         c0_reg;
    logic                lt_reg;
    logic [15:0]         nrm_reg;
    logic signed [16:0]  edge_reg;
    logic                high_reg;
    logic signed [15:0]  ramp_reg;
    logic signed [15:0]  tri_reg;
    logic signed [15:0]  v1_reg;
    logic                tpos_reg;
    logic signed [15:0]  mag_reg;
    logic                rpos_reg;
    logic                soft_reg;
    logic signed [15:0]  sine_reg;
    logic [17:0]         bprod_reg;
    logic signed [15:0]  saw_reg;
    logic signed [15:0]  a_reg;
    logic                direct_reg;
    logic signed [17:0]  blend_reg;
    logic                out_valid_reg;
    logic signed [15:0]  out_sample_reg;
    logic                out_high_reg;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [15:0]         div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic                out_free;
    logic                out_load;

    // Load stage
    logic [31:0]         u;
    logic [47:0]         xw;
    logic [15:0]         x;
    logic signed [47:0]  nw;
    logic signed [15:0]  nq;
    logic [15:0]         nrm;
    logic signed [16:0]  c0_full;
    logic                x_lt;
    logic                morph_zero;
    logic                pwm_mode;
    logic signed [15:0]  ramp_load;
    logic signed [16:0]  morph_ext;
    logic [16:0]         den_lo;
    logic [16:0]         den_hi;

    // Ramp stage
    logic [15:0]         rmul_a;
    logic [31:0]         rmul;
    logic signed [15:0]  ramp_bent;

    // Shape stage
    logic signed [17:0]  ts;
    logic signed [17:0]  ts2;
    logic signed [17:0]  ts3;
    logic signed [17:0]  tri_w;
    logic signed [15:0]  tri_v;
    logic                tpos;
    logic signed [16:0]  tneg;
    logic signed [15:0]  v0;
    logic signed [16:0]  v1_w;
    logic                rpos;
    logic signed [16:0]  rneg;
    logic signed [15:0]  mag;

    // Sine, saw and blend stages
    logic signed [31:0]  vv;
    logic signed [15:0]  v2;
    logic signed [16:0]  v3_w;
    logic signed [16:0]  sine_neg;
    logic signed [16:0]  sdiff;
    logic [33:0]         bmul;
    logic [35:0]         bsq;
    logic signed [18:0]  bval;
    logic signed [18:0]  saw_w;
    logic signed [17:0]  wc0;
    logic [31:0]         wc0_ext;
    logic [31:0]         frac;
    logic signed [15:0]  blend_a;
    logic signed [15:0]  blend_b;
    logic                blend_direct;
    logic signed [16:0]  bdiff;
    logic signed [49:0]  bprod_full;
    logic signed [17:0]  res_w;
    logic signed [15:0]  res;

    mwo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Ramp position x = (2 * phase * 65535) >> 32, done as a shift and subtract.
    assign u  = {job_reg.phase[30:0], 1'b0};
    assign xw = {u, 16'b0} - {16'b0, u};
    assign x  = xw[47:32];

    assign nw  = {job_reg.incr, 16'b0} - {{16{job_reg.incr[31]}}, job_reg.incr};
    assign nq  = nw[47:32];
    assign nrm = (nq < 0) ? 16'(-nq) : nq;

    assign morph_ext  = {job_reg.morph[15], job_reg.morph};
    assign c0_full    = morph_ext + 17'sd32767;
    assign x_lt       = (x < c0_full[15:0]);
    assign morph_zero = (job_reg.morph == 16'sd0);
    assign pwm_mode   = (job_reg.wave == PWM_SELECT);
    assign den_lo     = HALF_RANGE + 17'(morph_ext);
    assign den_hi     = HALF_RANGE - 17'(morph_ext);

    always_comb
    begin
        priority if (morph_zero)
        begin
            ramp_load = $signed(x - 16'(FULL_SCALE));
        end
        else if (x_lt)
        begin
            ramp_load = -16'(FULL_SCALE);
        end
        else
        begin
            ramp_load = 16'sd0;
        end
    end

    assign rmul_a    = lt_reg ? x_reg : (x_reg - c0_reg);
    assign rmul      = rmul_a * div_q[15:0];
    assign ramp_bent = lt_reg ? $signed(rmul[26:11] - 16'(FULL_SCALE))
                              : $signed(rmul[26:11]);

    // Triangle: fold the quarter-shifted ramp about zero.
    assign ts    = {{2{ramp_reg[15]}}, ramp_reg} - QUARTER_SCALE;
    assign ts2   = (ts < -FULL_SCALE) ? (ts + WRAP_SPAN) : ts;
    assign ts3   = (ts2 > 0) ? -ts2 : ts2;
    assign tri_w = (ts3 <<< 1) + FULL_SCALE;
    assign tri_v = tri_w[15:0];

    assign tpos = (tri_v > 0);
    assign tneg = -{tri_v[15], tri_v};
    assign v0   = tpos ? tri_v : tneg[15:0];
    assign v1_w = 17'sd32767 - {v0[15], v0};

    assign rpos = (ramp_reg > 0);
    assign rneg = -{ramp_reg[15], ramp_reg};
    assign mag  = rpos ? ramp_reg : rneg[15:0];

    assign vv       = v1_reg * v1_reg;
    assign v2       = vv[30:15];
    assign v3_w     = 17'sd32767 - {v2[15], v2};
    assign sine_neg = -{v3_w[15], v3_w[15:0]};

    assign sdiff = {mag_reg[15], mag_reg} - edge_reg;
    assign bmul  = sdiff[16:0] * div_q[16:0];
    assign bsq   = bprod_reg * bprod_reg;
    assign bval  = $signed({1'b0, bsq[32:15]});
    assign saw_w = rpos_reg ? ({{3{ramp_reg[15]}}, ramp_reg} - bval)
                            : ({{3{ramp_reg[15]}}, ramp_reg} + bval);

    // Blend fraction is (wave + 32767) * 196616 modulo 2^32, by shifts and adds.
    assign wc0     = {{2{job_reg.wave[15]}}, job_reg.wave} + FULL_SCALE;
    assign wc0_ext = {{14{wc0[17]}}, wc0};
    assign frac    = (wc0_ext << 17) + (wc0_ext << 16) + (wc0_ext << 3);

    always_comb
    begin
        priority if (wc0 < SEG_TRI)
        begin
            blend_a      = sine_reg;
            blend_b      = tri_reg;
            blend_direct = 1'b0;
        end
        else if (wc0 < SEG_SQUARE)
        begin
            blend_a      = tri_reg;
            blend_b      = ramp_reg[15] ? -16'sd32767 : 16'sd32767;
            blend_direct = (wc0 == SEG_TRI);
        end
        else if (wc0 < SEG_SAW)
        begin
            blend_a      = ramp_reg[15] ? -16'sd32767 : 16'sd32767;
            blend_b      = saw_reg;
            blend_direct = (wc0 == SEG_SQUARE);
        end
        else
        begin
            blend_a      = saw_reg;
            blend_b      = saw_reg;
            blend_direct = 1'b1;
        end
    end

    assign bdiff      = {blend_b[15], blend_b} - {blend_a[15], blend_a};
    assign bprod_full = bdiff * $signed({1'b0, frac});
    assign res_w      = {{2{a_reg[15]}}, a_reg} + blend_reg;
    assign res        = direct_reg ? a_reg : res_w[15:0];

    assign out_free = !out_valid_reg || audio.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                if (morph_zero || pwm_mode)
                begin
                    state_next = B_SHAPE;
                end
                else
                begin
                    state_next = B_RDIV;
                end
            end
            B_RDIV:
            begin
                if (div_done)
                begin
                    state_next = B_RAMP;
                end
            end
            B_RAMP:  state_next = B_SHAPE;
            B_SHAPE: state_next = B_SINE;
            B_SINE:
            begin
                if (soft_reg)
                begin
                    state_next = B_SDIV;
                end
                else
                begin
                    state_next = B_BLEND;
                end
            end
            B_SDIV:
            begin
                if (div_done)
                begin
                    state_next = B_SAWM;
                end
            end
            B_SAWM:  state_next = B_SAWS;
            B_SAWS:  state_next = B_BLEND;
            B_BLEND: state_next = B_OUT;
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = RAMP_DIVIDEND;
        div_divisor  = x_lt ? den_lo[15:0] : den_hi[15:0];
        out_load     = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop = !empty;
            B_LOAD:  div_start = !(morph_zero || pwm_mode);
            B_SINE:
            begin
                div_start    = soft_reg;
                div_dividend = SAW_DIVIDEND;
                div_divisor  = nrm_reg;
            end
            B_OUT:   out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (audio.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    job_reg <= rd_job;
                end
            end
            B_LOAD:
            begin
                x_reg    <= x;
                c0_reg   <= c0_full[15:0];
                lt_reg   <= x_lt;
                nrm_reg  <= nrm;
                edge_reg <= 17'sd32767 - $signed({1'b0, nrm});
                high_reg <= (job_reg.phase > 32'h8000_0000);
                ramp_reg <= ramp_load;
            end
            B_RAMP:
            begin
                ramp_reg <= ramp_bent;
            end
            B_SHAPE:
            begin
                tri_reg  <= tri_v;
                v1_reg   <= v1_w[15:0];
                tpos_reg <= tpos;
                mag_reg  <= mag;
                rpos_reg <= rpos;
                soft_reg <= ($signed({mag[15], mag}) > edge_reg);
            end
            B_SINE:
            begin
                sine_reg <= tpos_reg ? v3_w[15:0] : sine_neg[15:0];
                saw_reg  <= ramp_reg;
            end
            B_SAWM:
            begin
                bprod_reg <= bmul[17:0];
            end
            B_SAWS:
            begin
                saw_reg <= saw_w[15:0];
            end
            B_BLEND:
            begin
                a_reg      <= blend_a;
                direct_reg <= blend_direct;
                blend_reg  <= bprod_full[49:32];
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    out_sample_reg <= res;
                    out_high_reg   <= high_reg;
                end
            end
            default: ;
        endcase
    end

    assign audio.valid      = out_valid_reg;
    assign audio.sample_out = out_sample_reg;
    assign audio.sync_high  = out_high_reg;

endmodule

// ===== rtl/morphing_waveshape_oscillator.sv =====
// ----------------------------------------------------------------------------
// morphing_waveshape_oscillator
// Phase accumulator oscillator with linear FM, hard sync, morph and a
// sine/triangle/square/saw shape blend.
//
//   channel | dir | carries
//   --------+-----+------------------------------------------------------
//   ctrl    | in  | freq_step, fm_amount, morph_amount, wave_select, sync
//   audio   | out | sample_out, sync_high
//
// The front end captures a transaction, runs the FM multiply and the phase
// update, and takes no new one until that job is pushed, which waits while the
// queue is full. The back end works on one sample at a time and runs the shared
// divider once for a bent ramp and once more when the saw edge is softened.
// Reset clears the phase, the queue and the output valid flag. A stalled output
// holds the back end, which then fills the two-entry queue and stalls the input.
// ----------------------------------------------------------------------------
module morphing_waveshape_oscillator (
    input  logic        clk,
    input  logic        rst_n,
    mwo_ctrl_if.sink    ctrl,
    mwo_audio_if.source audio
);
    import mwo_pkg::*;

    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    mwo_job_t wr_job;
    mwo_job_t rd_job;

    mwo_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .push  (push),
        .job   (wr_job),
        .full  (full)
    );

    mwo_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty)
    );

    mwo_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_job (rd_job),
        .empty  (empty),
        .pop    (pop),
        .audio  (audio)
    );

endmodule
